// ----- rtl/rn_pkg.sv -----
// ----------------------------------------------------------------------------
// rn_pkg
// Shared constants, control word type and microcode ROM for the rational
// normalizer.
// ----------------------------------------------------------------------------
package rn_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int PC_W       = 4;

  // datapath operations
  localparam logic [3:0] OP_NOP        = 4'd0;
  localparam logic [3:0] OP_LOAD       = 4'd1;
  localparam logic [3:0] OP_SPECIAL    = 4'd2;
  localparam logic [3:0] OP_BOTH_SHIFT = 4'd3;
  localparam logic [3:0] OP_SHIFT_A    = 4'd4;
  localparam logic [3:0] OP_SHIFT_B    = 4'd5;
  localparam logic [3:0] OP_SUBSWAP    = 4'd6;
  localparam logic [3:0] OP_SCALE      = 4'd7;
  localparam logic [3:0] OP_DIV_STEP   = 4'd8;
  localparam logic [3:0] OP_DIV_NEXT   = 4'd9;
  localparam logic [3:0] OP_DIV_DONE   = 4'd10;
  localparam logic [3:0] OP_EMIT       = 4'd11;

  // branch conditions
  localparam logic [3:0] C_ALWAYS    = 4'd0;
  localparam logic [3:0] C_IN_VALID  = 4'd1;
  localparam logic [3:0] C_SPECIAL   = 4'd2;
  localparam logic [3:0] C_BOTH_EVEN = 4'd3;
  localparam logic [3:0] C_A_EVEN    = 4'd4;
  localparam logic [3:0] C_B_EVEN_NZ = 4'd5;
  localparam logic [3:0] C_B_NZ      = 4'd6;
  localparam logic [3:0] C_CNT_RUN   = 4'd7;
  localparam logic [3:0] C_OUT_FREE  = 4'd8;

  // program addresses
  localparam logic [PC_W-1:0] A_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] A_CHECK = 4'd1;
  localparam logic [PC_W-1:0] A_BOTH  = 4'd2;
  localparam logic [PC_W-1:0] A_ODDA  = 4'd3;
  localparam logic [PC_W-1:0] A_ODDB  = 4'd4;
  localparam logic [PC_W-1:0] A_SUB   = 4'd5;
  localparam logic [PC_W-1:0] A_SCALE = 4'd6;
  localparam logic [PC_W-1:0] A_DIVN  = 4'd7;
  localparam logic [PC_W-1:0] A_NEXT  = 4'd8;
  localparam logic [PC_W-1:0] A_DIVD  = 4'd9;
  localparam logic [PC_W-1:0] A_DONE  = 4'd10;
  localparam logic [PC_W-1:0] A_EMIT  = 4'd11;

  // when cond holds: run op, jump to target; else hold or fall through
  typedef struct packed {
    logic [3:0]      op;
    logic [3:0]      cond;
    logic [PC_W-1:0] target;
    logic            hold;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      A_IDLE:  w = '{OP_LOAD,       C_IN_VALID,  A_CHECK, 1'b1};
      A_CHECK: w = '{OP_SPECIAL,    C_SPECIAL,   A_EMIT,  1'b0};
      A_BOTH:  w = '{OP_BOTH_SHIFT, C_BOTH_EVEN, A_BOTH,  1'b0};
      A_ODDA:  w = '{OP_SHIFT_A,    C_A_EVEN,    A_ODDA,  1'b0};
      A_ODDB:  w = '{OP_SHIFT_B,    C_B_EVEN_NZ, A_ODDB,  1'b0};
      A_SUB:   w = '{OP_SUBSWAP,    C_B_NZ,      A_ODDB,  1'b0};
      A_SCALE: w = '{OP_SCALE,      C_ALWAYS,    A_DIVN,  1'b0};
      A_DIVN:  w = '{OP_DIV_STEP,   C_CNT_RUN,   A_DIVN,  1'b0};
      A_NEXT:  w = '{OP_DIV_NEXT,   C_ALWAYS,    A_DIVD,  1'b0};
      A_DIVD:  w = '{OP_DIV_STEP,   C_CNT_RUN,   A_DIVD,  1'b0};
      A_DONE:  w = '{OP_DIV_DONE,   C_ALWAYS,    A_EMIT,  1'b0};
      A_EMIT:  w = '{OP_EMIT,       C_OUT_FREE,  A_IDLE,  1'b1};
      default: w = '{OP_NOP,        C_ALWAYS,    A_IDLE,  1'b0};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/rn_if.sv -----
// ----------------------------------------------------------------------------
// rn_in_if / rn_out_if
// Valid/ready channels carrying the fraction in and the reduced fraction out.
// ----------------------------------------------------------------------------
interface rn_in_if #(
  parameter int DATA_WIDTH = rn_pkg::DATA_WIDTH
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] numerator_in;
  logic signed [DATA_WIDTH-1:0] denominator_in;

  modport source (output valid, numerator_in, denominator_in, input ready);
  modport sink   (input valid, numerator_in, denominator_in, output ready);
endinterface

interface rn_out_if #(
  parameter int DATA_WIDTH = rn_pkg::DATA_WIDTH
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] reduced_numerator;
  logic        [DATA_WIDTH-2:0] reduced_denominator;
  logic                         zero_denominator_error;

  modport source (output valid, reduced_numerator, reduced_denominator,
                  zero_denominator_error, input ready);
  modport sink   (input valid, reduced_numerator, reduced_denominator,
                  zero_denominator_error, output ready);
endinterface

// ----- rtl/rational_normalizer.sv -----
// ----------------------------------------------------------------------------
// rational_normalizer
// Reduces a signed fraction to lowest terms; sign on the numerator.
// ----------------------------------------------------------------------------
// One fraction is worked at a time. A zero numerator or denominator goes
// from accept through the check state straight to the result. Otherwise
// an item passes the load and check states, the binary GCD loop (one
// halving or one subtract-and-halve per cycle), then two restoring
// divisions of DATA_WIDTH-1 steps each on the one subtractor that the GCD
// loop also uses, plus the steps that scale, hand over and emit. A finished
// beat sits in the output register while the next item is accepted
// and worked. The most negative input pattern is treated as
// -(2^(DATA_WIDTH-1)-1). A zero denominator gives 0/0 with the error
// flag set.
module rational_normalizer #(
  parameter int DATA_WIDTH = rn_pkg::DATA_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  rn_in_if.sink      req,
  rn_out_if.source   rsp
);

  localparam int MW = DATA_WIDTH - 1;
  localparam int KW = $clog2(DATA_WIDTH);
  localparam logic [KW-1:0] LAST_STEP = KW'(MW);

  logic [rn_pkg::PC_W-1:0] pc;
  rn_pkg::ctrl_t           cw;
  logic                    cond_ok;

  logic [MW-1:0] na, nb, ga, gb, rem, quo;
  logic [KW-1:0] k, cnt;
  logic          sgn;
  logic [DATA_WIDTH-1:0] res_num;
  logic [MW-1:0]         res_den;
  logic                  res_err;

  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_num;
  logic [MW-1:0]         out_den;
  logic                  out_err;

  logic [MW-1:0] mag_a, mag_b;
  logic          neg_a, neg_b;

  logic          gt;
  logic [DATA_WIDTH-1:0] sub_x, sub_y;
  logic [DATA_WIDTH:0]   sub_r;
  logic                  borrow;

  function automatic logic [MW-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
    logic [DATA_WIDTH-1:0] n;
    n = -v;
    if (!v[DATA_WIDTH-1]) begin
      return v[MW-1:0];
    end else if (v[MW-1:0] == '0) begin
      return '1;
    end else begin
      return n[MW-1:0];
    end
  endfunction

  assign mag_a = magnitude(req.numerator_in);
  assign mag_b = magnitude(req.denominator_in);
  assign neg_a = req.numerator_in[DATA_WIDTH-1];
  assign neg_b = req.denominator_in[DATA_WIDTH-1];

  assign cw = rn_pkg::ucode(pc);

  always_comb begin
    case (cw.cond)
      rn_pkg::C_ALWAYS:    cond_ok = 1'b1;
      rn_pkg::C_IN_VALID:  cond_ok = req.valid;
      rn_pkg::C_SPECIAL:   cond_ok = (na == '0) || (nb == '0);
      rn_pkg::C_BOTH_EVEN: cond_ok = !ga[0] && !gb[0];
      rn_pkg::C_A_EVEN:    cond_ok = !ga[0];
      rn_pkg::C_B_EVEN_NZ: cond_ok = !gb[0] && (gb != '0);
      rn_pkg::C_B_NZ:      cond_ok = gb != '0;
      rn_pkg::C_CNT_RUN:   cond_ok = cnt != LAST_STEP;
      rn_pkg::C_OUT_FREE:  cond_ok = !out_valid || rsp.ready;
      default:             cond_ok = 1'b0;
    endcase
  end

  // shared subtractor: GCD difference or division trial
  assign gt = ga > gb;
  always_comb begin
    if (cw.op == rn_pkg::OP_SUBSWAP) begin
      sub_x = {1'b0, gt ? ga : gb};
      sub_y = {1'b0, gt ? gb : ga};
    end else begin
      sub_x = {rem, quo[MW-1]};
      sub_y = {1'b0, ga};
    end
  end
  assign sub_r  = {1'b0, sub_x} - {1'b0, sub_y};
  assign borrow = sub_r[DATA_WIDTH];

  assign req.ready = (pc == rn_pkg::A_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rn_pkg::A_IDLE;
    end else if (cond_ok) begin
      pc <= cw.target;
    end else if (!cw.hold) begin
      pc <= pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cond_ok) begin
      case (cw.op)
        rn_pkg::OP_LOAD: begin
          na  <= mag_a;
          nb  <= mag_b;
          ga  <= mag_a;
          gb  <= mag_b;
          sgn <= neg_a ^ neg_b;
          k   <= '0;
        end
        rn_pkg::OP_SPECIAL: begin
          res_num <= '0;
          res_den <= (nb == '0) ? '0 : MW'(1);
          res_err <= (nb == '0);
        end
        rn_pkg::OP_BOTH_SHIFT: begin
          ga <= ga >> 1;
          gb <= gb >> 1;
          k  <= k + 1'b1;
        end
        rn_pkg::OP_SHIFT_A: ga <= ga >> 1;
        rn_pkg::OP_SHIFT_B: gb <= gb >> 1;
        rn_pkg::OP_SUBSWAP: begin
          ga <= sub_y[MW-1:0];
          gb <= sub_r[MW:1];
        end
        rn_pkg::OP_SCALE: begin
          ga  <= ga << k;
          rem <= '0;
          quo <= na;
          cnt <= '0;
        end
        rn_pkg::OP_DIV_STEP: begin
          rem <= borrow ? sub_x[MW-1:0] : sub_r[MW-1:0];
          quo <= {quo[MW-2:0], !borrow};
          cnt <= cnt + 1'b1;
        end
        rn_pkg::OP_DIV_NEXT: begin
          res_num <= sgn ? -{1'b0, quo} : {1'b0, quo};
          res_err <= 1'b0;
          rem     <= '0;
          quo     <= nb;
          cnt     <= '0;
        end
        rn_pkg::OP_DIV_DONE: res_den <= quo;
        default: ;
      endcase
    end
  end

  // the last division step leaves its final quotient bit in quo
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cond_ok && cw.op == rn_pkg::OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cond_ok && cw.op == rn_pkg::OP_EMIT) begin
      out_num <= res_num;
      out_den <= res_den;
      out_err <= res_err;
    end
  end

  assign rsp.valid                  = out_valid;
  assign rsp.reduced_numerator      = out_num;
  assign rsp.reduced_denominator    = out_den;
  assign rsp.zero_denominator_error = out_err;

endmodule

// ----- rtl/rn_checker.sv -----
// ----------------------------------------------------------------------------
// rn_checker
// Port-level checks on the rational normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module rn_checker #(
  parameter int DATA_WIDTH = rn_pkg::DATA_WIDTH
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [DATA_WIDTH-1:0] rsp_num,
  input logic [DATA_WIDTH-2:0] rsp_den,
  input logic                  rsp_err
);

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat dropped while stalled");

  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_num) && $stable(rsp_den) && $stable(rsp_err))
    else $error("result beat changed while stalled");

  a_one_at_a_time : assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input taken while an item is in work");

  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_err |-> rsp_num == '0 && rsp_den == '0)
    else $error("error beat is not 0/0");

  a_den_nonzero : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_err |-> rsp_den != '0)
    else $error("zero denominator without error");

endmodule

bind rational_normalizer rn_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rn_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_num   (rsp.reduced_numerator),
  .rsp_den   (rsp.reduced_denominator),
  .rsp_err   (rsp.zero_denominator_error)
);
